[src/mlfw_pkg.sv]
// ----------------------------------------------------------------------------
// mlfw_pkg: shared types and constants of the monochrome LCD frame writer
// Geometry of the frame store, operation codes and the beat types of both
// channels.
// ----------------------------------------------------------------------------
`default_nettype none

package mlfw_pkg;

	// Frame geometry: COLUMNS byte cells per row bank, ROWS banks
	localparam int COLUMNS = 84;
	localparam int ROWS    = 6;
	localparam int DEPTH   = COLUMNS * ROWS;

	localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// Fixed field widths
	localparam int BYTE_W     = 8;
	localparam int CELL_W     = 9;
	localparam int OUT_COL_W  = 7;
	localparam int OUT_ROW_W  = 3;
	localparam int CELL_CMP_W = 12;

	// Operation codes
	localparam logic [1:0] OP_CMD  = 2'd0;
	localparam logic [1:0] OP_DATA = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	// Reset value of the clear code
	localparam logic [BYTE_W-1:0] CLEAR_CODE_RST = 8'h01;

	// Configuration register byte addresses
	localparam int PADDR_W = 2;
	localparam logic [PADDR_W-1:0] REG_CLEAR_CODE = 2'd0;

	typedef struct packed {
		logic [1:0]        operation;
		logic [BYTE_W-1:0] write_byte;
		logic [CELL_W-1:0] read_cell;
	} in_t;

	typedef struct packed {
		logic [BYTE_W-1:0]    read_data;
		logic [OUT_COL_W-1:0] cursor_column;
		logic [OUT_ROW_W-1:0] cursor_row;
	} out_t;

	typedef struct packed {
		logic [COL_W-1:0] column;
		logic [ROW_W-1:0] row;
	} cursor_t;

endpackage

`default_nettype wire

[src/mono_lcd_frame_writer.sv]
// ----------------------------------------------------------------------------
// mono_lcd_frame_writer: monochrome LCD controller with a byte frame store
// Input beats carry a command write, a data write or a read of one cell;
// each beat gives exactly one output beat with the read pixels (zero for
// writes) and the cursor after the beat. Both channels use valid/stall.
// out_valid is registered: an accepted beat passes the read stage, then the
// output register. One beat is taken per cycle while no sweep runs and out
// is not stalled: the single RAM port serves one cell access per beat.
// A command equal to clear_code starts a clearing sweep that writes zero
// to every cell, one per cycle, DEPTH (504) cells; in_stall stays high for
// the sweep. After reset the same sweep runs first, so the input is stalled
// until it ends; the cursor resets to column 0, row 0 and clear_code to 1.
// When the receiver stalls, the output register holds its beat, one more
// beat waits in the read stage, and then in_stall rises until out drains.
// clear_code is written through the APB port at byte address 0 and should
// only be changed while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module mono_lcd_frame_writer (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// input channel
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire mlfw_pkg::in_t              in_data,
	// output channel
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output mlfw_pkg::out_t                  out_data,
	// configuration
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [mlfw_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);

	import mlfw_pkg::*;

	logic [BYTE_W-1:0] clear_code_q;

	logic              accept;
	logic              clear_hit;
	logic              read_ok;
	cursor_t           cursor;
	logic [ADDR_W-1:0] cell_addr;

	logic              clr_busy_q;
	logic [ADDR_W-1:0] clr_cnt_q;

	logic              ram_en;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_addr;
	logic [BYTE_W-1:0] ram_wdata;
	logic [BYTE_W-1:0] ram_rdata;

	logic              s1_valid_s1;
	logic              s1_read_s1;
	logic              s1_adv;

	logic              out_valid_q;
	out_t              out_data_q;

	// Configuration port
	assign pready = 1'b1;
	assign prdata = (paddr == REG_CLEAR_CODE) ? 32'(clear_code_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_code_q <= CLEAR_CODE_RST;
		end else if (psel && penable && pwrite && (paddr == REG_CLEAR_CODE)) begin
			clear_code_q <= pwdata[BYTE_W-1:0];
		end
	end

	// Handshake
	assign s1_adv   = s1_valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = clr_busy_q || (s1_valid_s1 && !s1_adv);
	assign accept   = in_valid && !in_stall;
	assign read_ok  = CELL_CMP_W'(in_data.read_cell) < CELL_CMP_W'(DEPTH);

	mlfw_cursor u_cursor (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.operation  (in_data.operation),
		.write_byte (in_data.write_byte),
		.clear_code (clear_code_q),
		.cursor     (cursor),
		.cell_addr  (cell_addr),
		.clear_hit  (clear_hit)
	);

	// Clearing sweep, one cell per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (accept && clear_hit) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == ADDR_W'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// Sweep and beats never share a cycle: in_stall is high during the sweep
	always_comb begin
		ram_en    = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = clr_cnt_q;
		ram_wdata = '0;
		priority if (clr_busy_q) begin
			ram_en = 1'b1;
			ram_we = 1'b1;
		end else if (accept && (in_data.operation == OP_DATA)) begin
			ram_en    = 1'b1;
			ram_we    = 1'b1;
			ram_addr  = cell_addr;
			ram_wdata = in_data.write_byte;
		end else if (accept && (in_data.operation == OP_READ) && read_ok) begin
			ram_en   = 1'b1;
			ram_addr = ADDR_W'(in_data.read_cell);
		end else begin
			ram_en = 1'b0;
		end
	end

	mlfw_frame_ram #(
		.WIDTH  (BYTE_W),
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// Read stage: RAM data arrives here; no new beat is taken until it moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			s1_read_s1  <= 1'b0;
		end else if (accept) begin
			s1_valid_s1 <= 1'b1;
			s1_read_s1  <= (in_data.operation == OP_READ) && read_ok;
		end else if (s1_adv) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	// Output register; the cursor still reflects the beat in the read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_data_q.read_data     <= s1_read_s1 ? ram_rdata : '0;
			out_data_q.cursor_column <= OUT_COL_W'(cursor.column);
			out_data_q.cursor_row    <= OUT_ROW_W'(cursor.row);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

[src/mlfw_frame_ram.sv]
// ----------------------------------------------------------------------------
// mlfw_frame_ram: single-port synchronous RAM
// One access per cycle, write or read; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module mlfw_frame_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 504,
	parameter int ADDR_W = 9
) (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] addr,
	input  wire logic [WIDTH-1:0]  wdata,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

`default_nettype wire

[src/mlfw_cursor.sv]
// ----------------------------------------------------------------------------
// mlfw_cursor: write cursor of the frame writer
// Decodes command beats, advances the cursor on data beats and forms the
// store address of the current cell.
// ----------------------------------------------------------------------------
`default_nettype none

module mlfw_cursor (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      accept,
	input  wire logic [1:0]                operation,
	input  wire logic [mlfw_pkg::BYTE_W-1:0] write_byte,
	input  wire logic [mlfw_pkg::BYTE_W-1:0] clear_code,
	output mlfw_pkg::cursor_t              cursor,
	output logic [mlfw_pkg::ADDR_W-1:0]    cell_addr,
	output logic                           clear_hit
);

	import mlfw_pkg::*;

	cursor_t cur_q;
	cursor_t cur_d;

	logic col_ok;
	logic row_ok;
	logic col_last;
	logic row_last;

	assign col_ok   = {1'b0, write_byte[6:0]} < 8'(COLUMNS);
	assign row_ok   = {1'b0, write_byte[3:0]} < 5'(ROWS);
	assign col_last = cur_q.column == COL_W'(COLUMNS - 1);
	assign row_last = cur_q.row == ROW_W'(ROWS - 1);

	assign clear_hit = (operation == OP_CMD) && (write_byte == clear_code);

	always_comb begin
		cur_d = cur_q;
		priority if (operation == OP_CMD) begin
			// clear code wins over cursor moves
			priority if (write_byte == clear_code) begin
				cur_d = cur_q;
			end else if (write_byte[7]) begin
				if (col_ok) begin
					cur_d.column = COL_W'(write_byte[6:0]);
				end
			end else if (write_byte[6]) begin
				if (row_ok) begin
					cur_d.row = ROW_W'(write_byte[3:0]);
				end
			end else begin
				cur_d = cur_q;
			end
		end else if (operation == OP_DATA) begin
			if (col_last) begin
				cur_d.column = '0;
				cur_d.row    = row_last ? '0 : cur_q.row + 1'b1;
			end else begin
				cur_d.column = cur_q.column + 1'b1;
			end
		end else begin
			cur_d = cur_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
		end else if (accept) begin
			cur_q <= cur_d;
		end
	end

	assign cursor    = cur_q;
	assign cell_addr = ADDR_W'(ADDR_W'(cur_q.row) * ADDR_W'(COLUMNS))
		+ ADDR_W'(cur_q.column);

endmodule

`default_nettype wire

[src/mlfw_checker.sv]
// ----------------------------------------------------------------------------
// mlfw_checker: port-level checks of the frame writer
// Watches the top level's ports only; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module mlfw_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         in_valid,
	input wire logic                         in_stall,
	input wire mlfw_pkg::in_t                in_data,
	input wire logic                         out_valid,
	input wire logic                         out_stall,
	input wire mlfw_pkg::out_t               out_data,
	input wire logic                         psel,
	input wire logic                         penable,
	input wire logic                         pwrite,
	input wire logic [mlfw_pkg::PADDR_W-1:0] paddr,
	input wire logic [31:0]                  pwdata,
	input wire logic                         pready
);

	import mlfw_pkg::*;

	logic [BYTE_W-1:0] code_q;
	logic              clear_beat;

	// Track the clear code as seen on the configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_q <= CLEAR_CODE_RST;
		end else if (psel && penable && pwrite && pready && (paddr == REG_CLEAR_CODE)) begin
			code_q <= pwdata[BYTE_W-1:0];
		end
	end

	assign clear_beat = in_valid && !in_stall && (in_data.operation == OP_CMD)
		&& (in_data.write_byte == code_q);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("output beat changed while stalled");

	a_clear_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		clear_beat |=> in_stall)
		else $error("input taken during clearing sweep");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.cursor_column < OUT_COL_W'(COLUMNS))
		else $error("cursor column out of range");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 5'(out_data.cursor_row) < 5'(ROWS))
		else $error("cursor row out of range");

endmodule

bind mono_lcd_frame_writer mlfw_checker u_mlfw_checker (.*);

`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the monochrome LCD frame writer
// Drives command, data and cell-read beats with random gaps and output
// back-pressure. A mirror of the frame store and cursor predicts each output
// beat, which is compared field by field. clear_code is set over APB between
// phases, and read back after each write.
// ----------------------------------------------------------------------------

module testbench;

	import mlfw_pkg::*;

	localparam logic [1:0] OP_NONE = 2'd3;

	localparam int HOLD_CYCLES = 120;
	localparam int SWEEP_WAIT  = 600;
	localparam int TAIL_WAIT   = 20;
	localparam int CYCLE_LIMIT = 300000;
	localparam int CHUNK_ITEMS = 360;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_t         in_data;
	logic        out_valid;
	logic        out_stall;
	out_t        out_data;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// mirror of the display state
	logic [BYTE_W-1:0] pix_mem [DEPTH];
	int unsigned       cur_col;
	int unsigned       cur_row;
	int unsigned       last_cell;
	logic [BYTE_W-1:0] clr_code;

	out_t lcd_status_due [$];

	int   err_cnt;
	int   cyc_cnt;
	bit   tx_idle;
	bit   rx_idle;
	bit   hold_req;
	int   hold_left;

	mono_lcd_frame_writer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cyc_cnt++;
		if (cyc_cnt > CYCLE_LIMIT) begin
			$display("%0t: run stopped at cycle limit", $time);
			$display("testbench: errors");
			$finish;
		end
	end

	// receiver: random stalls, or a long hold-off on request
	initial begin
		out_stall = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				out_stall = 1'b1;
				hold_left--;
			end else begin
				out_stall = rx_idle && ($urandom_range(0, 99) < 35);
			end
		end
	end

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch: expected %0h actual %0h", $time, name, want, got);
			err_cnt++;
		end
	endfunction

	always @(posedge clk) begin : status_check
		out_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (lcd_status_due.size() == 0) begin
				$display("%0t: unexpected output beat: expected none actual %h",
					$time, out_data);
				err_cnt++;
			end else begin
				want = lcd_status_due.pop_front();
				check_field("read_data", want.read_data, out_data.read_data);
				check_field("cursor_column", want.cursor_column, out_data.cursor_column);
				check_field("cursor_row", want.cursor_row, out_data.cursor_row);
			end
		end
	end

	// advance the mirror by one accepted beat and queue the status it gives
	task automatic mirror_lcd(input in_t b);
		out_t        st;
		int unsigned idx;
		st.read_data = '0;
		case (b.operation)
			OP_CMD: begin
				if (b.write_byte == clr_code) begin
					foreach (pix_mem[i])
						pix_mem[i] = '0;
				end else if (b.write_byte[7]) begin
					if (b.write_byte[6:0] < COLUMNS)
						cur_col = b.write_byte[6:0];
				end else if (b.write_byte[6]) begin
					if (b.write_byte[3:0] < ROWS)
						cur_row = b.write_byte[3:0];
				end
			end
			OP_DATA: begin
				idx = cur_row * COLUMNS + cur_col;
				pix_mem[idx] = b.write_byte;
				last_cell = idx;
				cur_col++;
				if (cur_col >= COLUMNS) begin
					cur_col = 0;
					cur_row++;
					if (cur_row >= ROWS)
						cur_row = 0;
				end
			end
			OP_READ: begin
				if (b.read_cell < DEPTH)
					st.read_data = pix_mem[b.read_cell];
			end
			default: ;
		endcase
		st.cursor_column = OUT_COL_W'(cur_col);
		st.cursor_row    = OUT_ROW_W'(cur_row);
		lcd_status_due.push_back(st);
	endtask

	function automatic in_t beat(logic [1:0] op, logic [7:0] wb, logic [8:0] cell_idx);
		in_t b;
		b.operation  = op;
		b.write_byte = wb;
		b.read_cell  = cell_idx;
		return b;
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_beat(input in_t b);
		if (tx_idle) begin
			while ($urandom_range(0, 99) < 35) begin
				in_valid = 1'b0;
				@(negedge clk);
			end
		end
		in_valid = 1'b1;
		in_data  = b;
		do
			@(posedge clk);
		while (in_stall);
		mirror_lcd(b);
		@(negedge clk);
	endtask

	task automatic drain_output();
		in_valid = 1'b0;
		while (lcd_status_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_clear_code(input logic [7:0] code);
		logic [31:0] rd;
		drain_output();
		// a clearing sweep may still be running after its beat has come out
		repeat (SWEEP_WAIT) @(posedge clk);
		@(negedge clk);
		psel    = 1'b1;
		pwrite  = 1'b1;
		penable = 1'b0;
		paddr   = REG_CLEAR_CODE;
		pwdata  = 32'(code);
		@(negedge clk);
		penable = 1'b1;
		do
			@(posedge clk);
		while (!pready);
		clr_code = code;
		@(negedge clk);
		pwrite  = 1'b0;
		penable = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do
			@(posedge clk);
		while (!pready);
		rd = prdata;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		if (rd !== 32'(code)) begin
			$display("%0t: clear_code readback mismatch: expected %0h actual %0h",
				$time, code, rd);
			err_cnt++;
		end
	endtask

	function automatic in_t rand_beat();
		in_t         b;
		int unsigned r;
		b.operation  = OP_DATA;
		b.write_byte = 8'($urandom);
		b.read_cell  = 9'($urandom);
		r = $urandom_range(0, 99);
		if (r < 8) begin
			b.operation  = OP_CMD;
			b.write_byte = {1'b1, 7'($urandom_range(0, 90))};
		end else if (r < 14) begin
			b.operation  = OP_CMD;
			b.write_byte = {2'b01, 2'($urandom), 4'($urandom_range(0, 7))};
		end else if (r < 17) begin
			b.operation = OP_CMD;
		end else if (r < 18) begin
			b.operation  = OP_CMD;
			b.write_byte = clr_code;
		end else if (r < 55) begin
			b.operation = OP_DATA;
		end else if (r < 95) begin
			b.operation = OP_READ;
			// favour cells just written so reads see live data
			if ($urandom_range(0, 1))
				b.read_cell = 9'((last_cell + DEPTH - $urandom_range(0, 7)) % DEPTH);
			else if ($urandom_range(0, 9) == 0)
				b.read_cell = 9'($urandom_range(DEPTH, 511));
			else
				b.read_cell = 9'($urandom_range(0, DEPTH - 1));
		end else begin
			b.operation = OP_NONE;
		end
		return b;
	endfunction

	task automatic test_directed();
		send_beat(beat(OP_READ, 8'h00, 9'd0));
		send_beat(beat(OP_READ, 8'h00, 9'(DEPTH - 1)));
		send_beat(beat(OP_READ, 8'hFF, 9'h1FF));
		send_beat(beat(OP_DATA, 8'hFF, 9'h1FF));
		send_beat(beat(OP_DATA, 8'h00, 9'd0));
		send_beat(beat(OP_READ, 8'h00, 9'd0));
		send_beat(beat(OP_CMD, 8'h80 | 8'(COLUMNS - 1), 9'd0));
		send_beat(beat(OP_CMD, 8'h80 | 8'(COLUMNS), 9'd0));
		send_beat(beat(OP_CMD, 8'hFF, 9'd0));
		send_beat(beat(OP_CMD, 8'h40 | 8'(ROWS - 1), 9'd0));
		send_beat(beat(OP_CMD, 8'h40 | 8'(ROWS), 9'd0));
		send_beat(beat(OP_CMD, 8'h4F, 9'd0));
		send_beat(beat(OP_CMD, 8'h00, 9'd0));
		send_beat(beat(OP_CMD, 8'h3F, 9'd0));
		// last cell of the last row: the cursor wraps back to the origin
		send_beat(beat(OP_DATA, 8'hA5, 9'd0));
		send_beat(beat(OP_READ, 8'h00, 9'(DEPTH - 1)));
		send_beat(beat(OP_CMD, 8'h80 | 8'(COLUMNS - 1), 9'd0));
		send_beat(beat(OP_CMD, 8'h40, 9'd0));
		send_beat(beat(OP_DATA, 8'h5A, 9'd0));
		send_beat(beat(OP_READ, 8'h00, 9'(COLUMNS - 1)));
		send_beat(beat(OP_NONE, 8'hFF, 9'h1FF));
		// clear keeps the cursor where it is
		send_beat(beat(OP_CMD, clr_code, 9'd0));
		send_beat(beat(OP_READ, 8'h00, 9'(DEPTH - 1)));
		send_beat(beat(OP_READ, 8'h00, 9'd0));
	endtask

	// a clear code with bit 7 set must clear rather than move the column
	task automatic test_clear_precedence();
		set_clear_code(8'hC5);
		send_beat(beat(OP_DATA, 8'h3C, 9'd0));
		send_beat(beat(OP_CMD, 8'hC5, 9'd0));
		send_beat(beat(OP_READ, 8'h00, 9'(last_cell)));
	endtask

	task automatic test_random(input logic [7:0] code, input bit with_idle);
		set_clear_code(code);
		tx_idle = with_idle;
		rx_idle = with_idle;
		repeat (CHUNK_ITEMS)
			send_beat(rand_beat());
	endtask

	// hold the output off while the sender keeps offering beats
	task automatic test_backpressure();
		tx_idle  = 1'b0;
		rx_idle  = 1'b0;
		hold_req = 1'b1;
		repeat (40)
			send_beat(rand_beat());
		rx_idle = 1'b1;
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		err_cnt   = 0;
		cyc_cnt   = 0;
		tx_idle   = 1'b1;
		rx_idle   = 1'b1;
		hold_req  = 1'b0;
		cur_col   = 0;
		cur_row   = 0;
		last_cell = 0;
		clr_code  = CLEAR_CODE_RST;
		foreach (pix_mem[i])
			pix_mem[i] = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_clear_precedence();
		test_random(8'h00, 1'b1);
		test_random(8'hFF, 1'b0);
		test_backpressure();
		test_random(8'($urandom), 1'b1);
		test_random(8'h45, 1'b1);

		tx_idle = 1'b0;
		rx_idle = 1'b0;
		drain_output();
		repeat (TAIL_WAIT) @(posedge clk);
		@(negedge clk);
		if (err_cnt == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
